// ===== src/atcr_pkg.sv =====
// Package for the tile collision resolver: register indexes, request codes, widths, FSM states.
// No dependencies.
package atcr_pkg;
   localparam logic [1:0] CSR_MAP_WIDTH = 2'd0;
   localparam logic [1:0] CSR_MAP_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_TILE_SIZE = 2'd2;
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_RESOLVE = 1'b1;
   localparam int POS_W = 20;
   localparam int WIDE_W = 26;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLR, ST_DIV, ST_SETUP, ST_ISSUE, ST_CHECK, ST_PASS_END, ST_OUT
   } state_type;
endpackage

// ===== src/atcr_div.sv =====
// Iterative unsigned divider, one quotient bit per cycle (restoring).
// Depends on atcr_pkg.
module atcr_div
   import atcr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [WIDE_W-1:0]   dividend,
   input  logic [12:0]         divisor,
   output logic                done,
   output logic [WIDE_W-1:0]   quotient
);
   localparam int CW = $clog2(WIDE_W + 1);
   logic [WIDE_W-1:0] q_ff, q_in;
   logic [13:0] r_ff, r_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [13:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {r_ff[12:0], q_ff[WIDE_W-1]};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         cnt_in = CW'(WIDE_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            r_in = trial - {1'b0, divisor};
            q_in = {q_ff[WIDE_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[WIDE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
   end

   assign done = busy_ff && (cnt_ff == CW'(1));
   assign quotient = q_in;
endmodule

// ===== src/atcr_map_mem.sv =====
// Solid-bit tile memory: one write and one registered read port.
// Depends on atcr_pkg.
module atcr_map_mem
   import atcr_pkg::*;
#(
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic                     wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic                     rd_data
);
   logic mem [DEPTH];
   logic rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

// ===== src/aabb_tile_collision_resolve.sv =====
// Top level of the AABB versus tile map collision resolver.
// Depends on atcr_pkg, atcr_div, atcr_map_mem.
//
// A write beat writes the map memory as it is taken, if its tile lies in the map.
// A resolve beat runs two passes; each pass does four serial divisions (one
// quotient bit a cycle) and then reads (MAX_SPAN+1)^2 tiles from the map memory
// one after another. After reset every memory entry is cleared, one entry a
// cycle, before any beat is accepted. The result register holds one beat, and
// the next request is taken while it waits.
module aabb_tile_collision_resolve
   import atcr_pkg::*;
#(
   parameter int MAP_W_MAX = 64,
   parameter int MAP_H_MAX = 64,
   parameter int MAX_SPAN = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [8:0]         csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic [5:0]         req_tile_col,
   input  logic [5:0]         req_tile_row,
   input  logic               req_tile_is_solid,
   input  logic signed [19:0] req_box_x,
   input  logic signed [19:0] req_box_y,
   input  logic [15:0]        req_box_w,
   input  logic [15:0]        req_box_h,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [19:0] rsp_fixed_x,
   output logic signed [19:0] rsp_fixed_y,
   output logic               rsp_span_clipped
);
   localparam int CB = (MAP_W_MAX > 1) ? $clog2(MAP_W_MAX) : 1;
   localparam int RB = (MAP_H_MAX > 1) ? $clog2(MAP_H_MAX) : 1;
   localparam int DEPTH = MAP_W_MAX * MAP_H_MAX;
   localparam int AB = $clog2(DEPTH);
   localparam int SB = $clog2(MAX_SPAN + 1);
   localparam int SW = 28;  // signed working width

   state_type st_ff, st_in;
   logic [6:0] mw_ff, mh_ff;
   logic [8:0] ts_ff;
   logic [AB:0] clr_ff;
   logic signed [SW-1:0] px_ff, py_ff, rx_ff;
   logic [15:0] w_ff, h_ff;
   logic signed [SW-1:0] q_ff [4];
   logic [1:0] dsel_ff;
   logic axis_ff, clip_ff;
   logic [SB-1:0] ci_ff, ri_ff;
   logic signed [SW-1:0] tc_ff, tr_ff;
   logic inmap_ff;
   logic rv_ff;
   logic signed [19:0] ox_ff, oy_ff;
   logic oclip_ff;
   logic div_go_ff;

   logic [12:0] tsz;
   logic [8:0] ts_eff;
   logic signed [SW-1:0] t_s, w_s, h_s;
   logic signed [SW-1:0] dnum, lo_x, lo_y, hi_x, hi_y, tx, ty, res;
   logic [WIDE_W-1:0] dabs, dq;
   logic dstart, ddone;
   logic [6:0] mw_eff, mh_eff;
   logic mem_we, mem_wd, rd;
   logic [AB-1:0] wa, ra;
   logic take_req;

   assign ts_eff = (ts_ff == 9'd0) ? 9'd1 : (ts_ff > 9'd256) ? 9'd256 : ts_ff;
   assign tsz = {ts_eff, 4'd0};
   assign t_s = SW'(tsz);
   assign w_s = SW'(w_ff);
   assign h_s = SW'(h_ff);
   assign mw_eff = (32'(mw_ff) > MAP_W_MAX) ? 7'(MAP_W_MAX) : mw_ff;
   assign mh_eff = (32'(mh_ff) > MAP_H_MAX) ? 7'(MAP_H_MAX) : mh_ff;

   always_comb begin
      case (dsel_ff)
         2'd0: dnum = px_ff;
         2'd1: dnum = px_ff + w_s;
         2'd2: dnum = py_ff;
         default: dnum = py_ff + h_s;
      endcase
   end
   assign dabs = dnum[SW-1] ? WIDE_W'(-dnum) : WIDE_W'(dnum);

   atcr_div u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(dabs),
      .divisor(tsz), .done(ddone), .quotient(dq)
   );

   assign lo_x = q_ff[0];
   assign lo_y = q_ff[2];
   assign hi_x = (q_ff[1] > lo_x + SW'(MAX_SPAN)) ? lo_x + SW'(MAX_SPAN) : q_ff[1];
   assign hi_y = (q_ff[3] > lo_y + SW'(MAX_SPAN)) ? lo_y + SW'(MAX_SPAN) : q_ff[3];
   assign tx = tc_ff * $signed({1'b0, tsz});
   assign ty = tr_ff * $signed({1'b0, tsz});

   assign take_req = req_valid && req_ready;
   assign mem_we = (st_ff == ST_CLR) || (take_req && req_type == REQ_WRITE
                   && 32'(req_tile_col) < MAP_W_MAX && 32'(req_tile_row) < MAP_H_MAX);
   assign wa = (st_ff == ST_CLR) ? clr_ff[AB-1:0]
             : AB'(32'(req_tile_row) * MAP_W_MAX + 32'(req_tile_col));
   assign mem_wd = (st_ff == ST_CLR) ? 1'b0 : req_tile_is_solid;
   assign ra = AB'(tr_ff[RB-1:0] * MAP_W_MAX + tc_ff[CB-1:0]);

   atcr_map_mem #(.DEPTH(DEPTH)) u_mem (
      .clock(clock), .wr_en(mem_we), .wr_addr(wa), .wr_data(mem_wd),
      .rd_addr(ra), .rd_data(rd)
   );

   assign req_ready = (st_ff == ST_IDLE);
   // divider start comes from the registered kick
   assign dstart = div_go_ff;

   // hit test on registered tile
   logic hit;
   always_comb begin
      hit = rd && inmap_ff
         && px_ff < tx + t_s && px_ff + w_s > tx
         && py_ff < ty + t_s && py_ff + h_s > ty;
      if (!axis_ff) res = (px_ff < tx) ? tx - w_s : tx + t_s;
      else res = (py_ff < ty) ? ty - h_s : ty + t_s;
   end

   function automatic logic signed [SW-1:0] sat(input logic signed [SW-1:0] v);
      if (v > SW'(524287)) sat = SW'(524287);
      else if (v < -SW'(524288)) sat = -SW'(524288);
      else sat = v;
   endfunction

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_CLR: if (clr_ff == (AB+1)'(DEPTH - 1)) st_in = ST_IDLE;
         ST_IDLE: if (take_req && req_type == REQ_RESOLVE) st_in = ST_DIV;
         ST_DIV: if (ddone && dsel_ff == 2'd3) st_in = ST_SETUP;
         ST_SETUP: st_in = ST_ISSUE;
         ST_ISSUE: st_in = ST_CHECK;
         ST_CHECK: if (ci_ff == SB'(MAX_SPAN) && ri_ff == SB'(MAX_SPAN)) st_in = ST_PASS_END;
                   else st_in = ST_ISSUE;
         ST_PASS_END: st_in = axis_ff ? ST_OUT : ST_DIV;
         ST_OUT: if (!rv_ff || rsp_ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_CLR;
         clr_ff <= '0;
         mw_ff <= 7'd64;
         mh_ff <= 7'd64;
         ts_ff <= 9'd16;
         rv_ff <= 1'b0;
         div_go_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_CLR) clr_ff <= clr_ff + 1'b1;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_MAP_WIDTH: mw_ff <= csr_write_data[6:0];
               CSR_MAP_HEIGHT: mh_ff <= csr_write_data[6:0];
               CSR_TILE_SIZE: ts_ff <= csr_write_data;
               default: ;
            endcase
         end
         div_go_ff <= (st_in == ST_DIV) && (st_ff != ST_DIV || ddone) && !(ddone && dsel_ff == 2'd3);
         if (st_ff == ST_OUT && (!rv_ff || rsp_ready)) rv_ff <= 1'b1;
         else if (rsp_ready) rv_ff <= 1'b0;
      end
      if (take_req) begin
         px_ff <= SW'(req_box_x);
         py_ff <= SW'(req_box_y);
         w_ff <= req_box_w;
         h_ff <= req_box_h;
         dsel_ff <= 2'd0;
         axis_ff <= 1'b0;
         clip_ff <= 1'b0;
      end
      if (st_ff == ST_DIV && ddone) begin
         q_ff[dsel_ff] <= dnum[SW-1] ? -SW'(dq) : SW'(dq);
         dsel_ff <= dsel_ff + 1'b1;
      end
      if (st_ff == ST_SETUP) begin
         ci_ff <= '0;
         ri_ff <= '0;
         rx_ff <= axis_ff ? py_ff : px_ff;
         if (q_ff[1] > lo_x + SW'(MAX_SPAN) || q_ff[3] > lo_y + SW'(MAX_SPAN)) clip_ff <= 1'b1;
         tc_ff <= lo_x;
         tr_ff <= lo_y;
      end
      if (st_ff == ST_ISSUE)
         inmap_ff <= tc_ff <= hi_x && tr_ff <= hi_y && tc_ff >= 0 && tr_ff >= 0
                  && tc_ff < SW'(mw_eff) && tr_ff < SW'(mh_eff);
      if (st_ff == ST_CHECK) begin
         if (hit) rx_ff <= res;
         if (ci_ff == SB'(MAX_SPAN)) begin
            ci_ff <= '0;
            ri_ff <= ri_ff + 1'b1;
            tc_ff <= lo_x;
            tr_ff <= tr_ff + 1'b1;
         end else begin
            ci_ff <= ci_ff + 1'b1;
            tc_ff <= tc_ff + 1'b1;
         end
      end
      if (st_ff == ST_PASS_END) begin
         if (!axis_ff) px_ff <= sat(rx_ff);
         else py_ff <= sat(rx_ff);
         axis_ff <= 1'b1;
         dsel_ff <= 2'd0;
      end
      if (st_ff == ST_OUT && (!rv_ff || rsp_ready)) begin
         ox_ff <= px_ff[19:0];
         oy_ff <= py_ff[19:0];
         oclip_ff <= clip_ff;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_fixed_x = ox_ff;
   assign rsp_fixed_y = oy_ff;
   assign rsp_span_clipped = oclip_ff;

   a_div_kick: assert property (@(posedge clock) disable iff (reset)
      dstart |-> st_ff == ST_DIV) else $error("divider started outside division");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> st_ff == ST_IDLE) else $error("ready outside idle");
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_CHECK) |-> !mem_we) else $error("map written during walk");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_ready |=> rv_ff && $stable(ox_ff)) else $error("result lost");
endmodule
